// ===== rtl/rgb_to_hls_pixel_core_defines.svh =====
// Assertion macros used by the checker file of the pixel converter.
`ifndef RGB_TO_HLS_PIXEL_CORE_DEFINES_SVH
`define RGB_TO_HLS_PIXEL_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off while arst_n is low.
`define RTHLS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and switched off while arst_n is low.
`define RTHLS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rthls_pkg.sv =====
// Types, constants and divider step functions for the RGB to HLS converter.
package rthls_pkg;

	localparam logic [7:0]  LIG_MID   = 8'd128;
	localparam logic [8:0]  DEN_TOP   = 9'd511;
	localparam logic [10:0] SEC_ONE   = 11'd255;
	localparam logic [10:0] SEC_THREE = 11'd765;
	localparam logic [10:0] SEC_FIVE  = 11'd1275;
	// floor(x/6) == (x*683) >> 12 for every sector value up to 1530.
	localparam logic [9:0]  RECIP_SIX = 10'd683;
	localparam int unsigned DIV_STEPS = 8;

	// Classified pixel, handed from the front part to the back part.
	typedef struct packed {
		logic        zero;  // grey or zero lightness: hue and saturation are 0
		logic [7:0]  lig;
		logic [7:0]  span;  // max - min, divisor of the hue distance
		logic [8:0]  den;   // divisor of the saturation quotient
		logic [7:0]  hnum;  // max minus the component that sets the hue
		logic [10:0] base;  // sector base
		logic        sub;   // distance is subtracted from the base
	} cls_t;

	// Partial state of a restoring division with an 8-bit quotient.
	typedef struct packed {
		logic [8:0] rem;
		logic [7:0] lo;
		logic [7:0] quot;
	} div_t;

	// One divider stage of the back part.
	typedef struct packed {
		div_t        sdiv;
		div_t        hdiv;
		logic [8:0]  sden;
		logic [8:0]  hden;
		logic [7:0]  lig;
		logic        zero;
		logic [10:0] base;
		logic        sub;
	} bst_t;

	// Loads 255*a as the dividend; its upper byte is below any valid divisor.
	function automatic div_t div_init(input logic [7:0] a);
		logic [15:0] num;
		div_t        r;
		num    = {a, 8'h00} - {8'h00, a};
		r.rem  = {1'b0, num[15:8]};
		r.lo   = num[7:0];
		r.quot = 8'h00;
		return r;
	endfunction

	// One quotient bit: shift in the next dividend bit, then compare and subtract.
	function automatic div_t div_step(input div_t s, input logic [8:0] d);
		logic [9:0] trial;
		logic [9:0] diff;
		div_t       r;
		trial = {s.rem, s.lo[7]};
		diff  = trial - {1'b0, d};
		r.lo  = {s.lo[6:0], 1'b0};
		if (trial >= {1'b0, d}) begin
			r.rem  = diff[8:0];
			r.quot = {s.quot[6:0], 1'b1};
		end else begin
			r.rem  = trial[8:0];
			r.quot = {s.quot[6:0], 1'b0};
		end
		return r;
	endfunction

endpackage

// ===== rtl/rthls_front.sv =====
// Front part: finds max and min, lightness, and picks the hue sector.
module rthls_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          red,
	input  logic [7:0]          green,
	input  logic [7:0]          blue,
	output logic                out_valid,
	input  logic                out_ready,
	output rthls_pkg::cls_t     out_cls
);

	logic [7:0]      mx, mn, span;
	logic [8:0]      sum;
	logic [7:0]      lig;
	rthls_pkg::cls_t cls;
	rthls_pkg::cls_t cls_s1;
	logic            vld_s1;

	always_comb begin
		mx = (red > green) ? red : green;
		if (blue > mx) mx = blue;
		mn = (red < green) ? red : green;
		if (blue < mn) mn = blue;
		sum  = {1'b0, mx} + {1'b0, mn};
		lig  = sum[8:1];
		span = mx - mn;

		cls.zero = (lig == 8'd0) || (span == 8'd0);
		cls.lig  = lig;
		cls.span = span;
		cls.den  = (lig <= rthls_pkg::LIG_MID) ? sum : (rthls_pkg::DEN_TOP - sum);

		// Ties for the maximum go to red first, then green.
		if (red == mx) begin
			if (green == mn) begin
				cls.base = rthls_pkg::SEC_FIVE;
				cls.hnum = mx - blue;
				cls.sub  = 1'b0;
			end else begin
				cls.base = rthls_pkg::SEC_ONE;
				cls.hnum = mx - green;
				cls.sub  = 1'b1;
			end
		end else if (green == mx) begin
			if (blue == mn) begin
				cls.base = rthls_pkg::SEC_ONE;
				cls.hnum = mx - red;
				cls.sub  = 1'b0;
			end else begin
				cls.base = rthls_pkg::SEC_THREE;
				cls.hnum = mx - blue;
				cls.sub  = 1'b1;
			end
		end else begin
			if (red == mn) begin
				cls.base = rthls_pkg::SEC_THREE;
				cls.hnum = mx - green;
				cls.sub  = 1'b0;
			end else begin
				cls.base = rthls_pkg::SEC_FIVE;
				cls.hnum = mx - red;
				cls.sub  = 1'b1;
			end
		end
	end

	assign in_ready  = !vld_s1 || out_ready;
	assign out_valid = vld_s1;
	assign out_cls   = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cls_s1 <= cls;
		end
	end

endmodule

// ===== rtl/rthls_queue.sv =====
// Short queue of classified pixels between the front and back parts.
module rthls_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  rthls_pkg::cls_t in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output rthls_pkg::cls_t out_data
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	rthls_pkg::cls_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            push, pop;

	assign in_ready  = (cnt_q != FULL);
	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

// ===== rtl/rthls_back.sv =====
// Back part: pipelined dividers for saturation and hue, sector sum and scaling.
module rthls_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  rthls_pkg::cls_t in_cls,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      hue,
	output logic [7:0]      lightness,
	output logic [7:0]      saturation
);

	localparam int unsigned NST = rthls_pkg::DIV_STEPS + 2;

	rthls_pkg::bst_t div_s [1:rthls_pkg::DIV_STEPS];
	rthls_pkg::bst_t nxt   [2:rthls_pkg::DIV_STEPS];
	rthls_pkg::bst_t first;
	logic            vld_s [1:NST];
	logic            en    [1:NST];

	logic [10:0] sec_s9;
	logic [7:0]  lig_s9, sat_s9;
	logic        zero_s9;
	logic [7:0]  hue_s10, lig_s10, sat_s10;

	logic [10:0] sector;
	logic [20:0] prod;
	logic [7:0]  hq;

	// A stage loads when it is empty or its successor is loading.
	always_comb begin
		en[NST] = !vld_s[NST] || out_ready;
		for (int k = NST - 1; k >= 1; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign in_ready = en[1];

	always_comb begin
		first.sden = in_cls.den;
		first.hden = {1'b0, in_cls.span};
		first.sdiv = rthls_pkg::div_step(rthls_pkg::div_init(in_cls.span), in_cls.den);
		first.hdiv = rthls_pkg::div_step(rthls_pkg::div_init(in_cls.hnum),
			{1'b0, in_cls.span});
		first.lig  = in_cls.lig;
		first.zero = in_cls.zero;
		first.base = in_cls.base;
		first.sub  = in_cls.sub;
	end

	// Next contents of each later divider stage: the word moves on and both
	// dividers take one more quotient bit.
	always_comb begin
		for (int k = 2; k <= rthls_pkg::DIV_STEPS; k++) begin
			nxt[k]      = div_s[k-1];
			nxt[k].sdiv = rthls_pkg::div_step(div_s[k-1].sdiv, div_s[k-1].sden);
			nxt[k].hdiv = rthls_pkg::div_step(div_s[k-1].hdiv, div_s[k-1].hden);
		end
	end

	always_comb begin
		hq     = div_s[rthls_pkg::DIV_STEPS].hdiv.quot;
		sector = div_s[rthls_pkg::DIV_STEPS].sub ?
			(div_s[rthls_pkg::DIV_STEPS].base - {3'b000, hq}) :
			(div_s[rthls_pkg::DIV_STEPS].base + {3'b000, hq});
		prod   = {10'd0, sec_s9} * {11'd0, rthls_pkg::RECIP_SIX};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NST; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			if (en[1]) begin
				vld_s[1] <= in_valid;
			end
			for (int k = 2; k <= NST; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			div_s[1] <= first;
		end
		for (int k = 2; k <= rthls_pkg::DIV_STEPS; k++) begin
			if (en[k]) begin
				div_s[k] <= nxt[k];
			end
		end
		if (en[NST-1]) begin
			sec_s9  <= sector;
			lig_s9  <= div_s[rthls_pkg::DIV_STEPS].lig;
			sat_s9  <= div_s[rthls_pkg::DIV_STEPS].sdiv.quot;
			zero_s9 <= div_s[rthls_pkg::DIV_STEPS].zero;
		end
		if (en[NST]) begin
			hue_s10 <= zero_s9 ? 8'd0 : prod[19:12];
			lig_s10 <= lig_s9;
			sat_s10 <= zero_s9 ? 8'd0 : sat_s9;
		end
	end

	assign out_valid  = vld_s[NST];
	assign hue        = hue_s10;
	assign lightness  = lig_s10;
	assign saturation = sat_s10;

endmodule

// ===== rtl/rgb_to_hls_pixel_core.sv =====
// RGB to HLS pixel converter: top level joining front part, queue and back part.
// Throughput: one pixel word per clock while the output is not stalled; every stage and
// both dividers are pipelined. From input acceptance to output valid a word passes the
// front register, the queue, eight divider steps, a sector stage and the output
// register. Reset (arst_n low) empties every stage and the queue at once.
module rgb_to_hls_pixel_core #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // hue [7:0], lightness [15:8], saturation [23:16]
);

	// The front part classifies a word and registers it: it finds the largest and
	// smallest components, the lightness, the two divisors and the hue sector.
	// Its output register takes a new word while the queue is full only if the
	// register is empty.
	logic            f_valid, f_ready;
	rthls_pkg::cls_t f_cls;

	// The queue between the parts absorbs short stalls of the back part, so the
	// front keeps accepting words while results wait at the output.
	logic            q_valid, q_ready;
	rthls_pkg::cls_t q_cls;

	logic [7:0] hue, lightness, saturation;

	rthls_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.red       (s_tdata[7:0]),
		.green     (s_tdata[15:8]),
		.blue      (s_tdata[23:16]),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_cls   (f_cls)
	);

	rthls_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   (f_cls),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_data  (q_cls)
	);

	// The back part runs both divisions side by side, one quotient bit per stage,
	// so that a new word may enter every cycle. Each stage stalls only when it
	// holds a word and the stage after it cannot take it.
	rthls_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (q_valid),
		.in_ready   (q_ready),
		.in_cls     (q_cls),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.hue        (hue),
		.lightness  (lightness),
		.saturation (saturation)
	);

	assign m_tdata = {saturation, lightness, hue};

endmodule

// ===== rtl/rthls_checker.sv =====
// Port-level checker for the RGB to HLS converter, bound to the top level.
`include "rgb_to_hls_pixel_core_defines.svh"

module rthls_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [23:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	logic [7:0] outst_q;
	logic       in_acc, out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outst_q <= 8'd0;
		end else if (in_acc && !out_acc) begin
			outst_q <= outst_q + 8'd1;
		end else if (out_acc && !in_acc) begin
			outst_q <= outst_q - 8'd1;
		end
	end

	`RTHLS_ASSERT_NOW(no_orphan_word, out_acc, outst_q != 8'd0, "output word with no input word outstanding")
	`RTHLS_ASSERT_NOW(idle_ready, outst_q == 8'd0, s_tready, "empty converter refuses input")
	`RTHLS_ASSERT_NEXT(out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled output word changed")
	`RTHLS_ASSERT_NOW(dark_is_flat, m_tvalid && (m_tdata[15:8] == 8'd0), (m_tdata[7:0] == 8'd0) && (m_tdata[23:16] == 8'd0), "zero lightness with nonzero hue or saturation")

endmodule

bind rgb_to_hls_pixel_core rthls_checker u_rthls_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/tb_rgb_to_hls_pixel_core.sv =====
// Self-checking testbench for the RGB to HLS pixel converter, with stream stalls on both sides.
module tb_rgb_to_hls_pixel_core;

	timeunit 1ns;
	timeprecision 1ps;

	// Pixel word as it travels on s_tdata: red in the lowest byte.
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pix_t;

	// Converted word as it travels on m_tdata: hue in the lowest byte.
	typedef struct packed {
		logic [7:0] sat;
		logic [7:0] lig;
		logic [7:0] hue;
	} hls_t;

	// One directed row. Where typed is set, the result is written out by hand.
	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		bit         typed;
		logic [7:0] hue;
		logic [7:0] lig;
		logic [7:0] sat;
	} row_t;

	// Sector bases of the hexcone hue.
	localparam logic [10:0] SECTOR_ONE   = 11'd255;
	localparam logic [10:0] SECTOR_THREE = 11'd765;
	localparam logic [10:0] SECTOR_FIVE  = 11'd1275;
	localparam logic [7:0]  LIG_HALF     = 8'd128;
	localparam logic [8:0]  SUM_TOP      = 9'd511;

	// Cycles without any accepted word before the run is declared hung. The
	// slowest legal stretch is a 75 per cent stall on one side, so an idle
	// stretch reaching this limit cannot happen in a healthy run.
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 24;
	localparam int RANDOM_PER_PHASE = 282;
	localparam int N_DIRECTED = 22;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // red [7:0], green [15:8], blue [23:16]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // hue [7:0], lightness [15:8], saturation [23:16]

	// Percentages of cycles in which the sender holds back and the receiver stalls.
	int unsigned gap_pct = 0;
	int unsigned stall_pct = 0;

	hls_t hls_pending[$];
	int   errors = 0;
	int   idle_cycles = 0;

	row_t dir_rows [N_DIRECTED] = '{
		// Black, white and mid grey: hue and saturation are zero.
		'{8'd0,   8'd0,   8'd0,   1'b1, 8'd0, 8'd0,   8'd0},
		'{8'd255, 8'd255, 8'd255, 1'b1, 8'd0, 8'd255, 8'd0},
		'{8'd128, 8'd128, 8'd128, 1'b1, 8'd0, 8'd128, 8'd0},
		// Near black: lightness rounds down to zero, so everything is zero.
		'{8'd1,   8'd0,   8'd0,   1'b1, 8'd0, 8'd0,   8'd0},
		'{8'd0,   8'd0,   8'd1,   1'b1, 8'd0, 8'd0,   8'd0},
		'{8'd1,   8'd1,   8'd0,   1'b1, 8'd0, 8'd0,   8'd0},
		// Primaries and secondaries, the latter with a tie for the maximum.
		'{8'd255, 8'd0,   8'd0,   1'b0, 8'd0, 8'd0,   8'd0},
		'{8'd0,   8'd255, 8'd0,   1'b0, 8'd0, 8'd0,   8'd0},
		'{8'd0,   8'd0,   8'd255, 1'b0, 8'd0, 8'd0,   8'd0},
		'{8'd255, 8'd255, 8'd0,   1'b0, 8'd0, 8'd0,   8'd0},
		'{8'd0,   8'd255, 8'd255, 1'b0, 8'd0, 8'd0,   8'd0},
		'{8'd255, 8'd0,   8'd255, 1'b0, 8'd0, 8'd0,   8'd0},
		// One pixel in each of the six sectors.
		'{8'd255, 8'd128, 8'd0,   1'b0, 8'd0, 8'd0,   8'd0},
		'{8'd128, 8'd255, 8'd0,   1'b0, 8'd0, 8'd0,   8'd0},
		'{8'd0,   8'd255, 8'd128, 1'b0, 8'd0, 8'd0,   8'd0},
		'{8'd0,   8'd128, 8'd255, 1'b0, 8'd0, 8'd0,   8'd0},
		'{8'd128, 8'd0,   8'd255, 1'b0, 8'd0, 8'd0,   8'd0},
		'{8'd255, 8'd0,   8'd128, 1'b0, 8'd0, 8'd0,   8'd0},
		// Either side of the lightness midpoint, where the divisor changes, then two light pixels.
		'{8'd129, 8'd128, 8'd128, 1'b0, 8'd0, 8'd0,   8'd0},
		'{8'd131, 8'd128, 8'd128, 1'b0, 8'd0, 8'd0,   8'd0},
		'{8'd255, 8'd200, 8'd200, 1'b0, 8'd0, 8'd0,   8'd0},
		'{8'd255, 8'd254, 8'd254, 1'b0, 8'd0, 8'd0,   8'd0}
	};

	rgb_to_hls_pixel_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [7:0] to_byte(input logic [15:0] v);
		return (v > 16'd255) ? 8'hFF : v[7:0];
	endfunction

	// Distance of one component below the maximum, scaled by the span.
	function automatic logic [7:0] hue_gap(input logic [7:0] hi, input logic [7:0] c,
			input logic [7:0] span);
		logic [15:0] q;
		q = (16'd255 * (hi - c)) / span;
		return to_byte(q);
	endfunction

	// Expected hue, lightness and saturation of one pixel.
	function automatic hls_t hls_of(input pix_t px);
		logic [7:0]  hi;
		logic [7:0]  lo;
		logic [7:0]  span;
		logic [8:0]  total;
		logic [8:0]  den;
		logic [7:0]  dr;
		logic [7:0]  dg;
		logic [7:0]  db;
		logic [10:0] sector;
		logic [15:0] quot;
		hls_t        res;
		hi = (px.red > px.green) ? px.red : px.green;
		if (px.blue > hi) hi = px.blue;
		lo = (px.red < px.green) ? px.red : px.green;
		if (px.blue < lo) lo = px.blue;
		total = {1'b0, hi} + {1'b0, lo};
		span = hi - lo;
		res = '0;
		res.lig = total[8:1];
		// Grey and near black leave hue and saturation at zero.
		if (res.lig != 8'd0 && span != 8'd0) begin
			den = (res.lig <= LIG_HALF) ? total : SUM_TOP - total;
			quot = (16'd255 * span) / den;
			res.sat = to_byte(quot);
			dr = hue_gap(hi, px.red, span);
			dg = hue_gap(hi, px.green, span);
			db = hue_gap(hi, px.blue, span);
			// Ties for the maximum go to red first, then green.
			if (px.red == hi)
				sector = (px.green == lo) ? SECTOR_FIVE + db : SECTOR_ONE - dg;
			else if (px.green == hi)
				sector = (px.blue == lo) ? SECTOR_ONE + dr : SECTOR_THREE - db;
			else
				sector = (px.red == lo) ? SECTOR_THREE + dg : SECTOR_FIVE - dr;
			quot = {5'd0, sector} / 16'd6;
			res.hue = to_byte(quot);
		end
		return res;
	endfunction

	// Random pixel, biased towards grey, near black, ties, corner colours and narrow spans.
	function automatic pix_t random_pixel();
		int unsigned kind;
		logic [7:0]  v;
		pix_t        px;
		kind = $urandom_range(0, 99);
		v = 8'($urandom);
		px = pix_t'($urandom);
		if (kind < 55) begin
			// fully random, already set
		end else if (kind < 63) begin
			px = '{v, v, v};
		end else if (kind < 71) begin
			px = '{8'($urandom_range(0, 1)), 8'($urandom_range(0, 1)),
				8'($urandom_range(0, 2))};
		end else if (kind < 81) begin
			// Two components are made equal.
			case ($urandom_range(0, 2))
				0: px.green = px.red;
				1: px.blue = px.green;
				default: px.red = px.blue;
			endcase
		end else if (kind < 89) begin
			px = '{($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00,
				($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00,
				($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00};
		end else begin
			// Components within a few steps of each other.
			px.red = v;
			px.green = v + 8'($urandom_range(0, 3));
			px.blue = v - 8'($urandom_range(0, 3));
		end
		return px;
	endfunction

	// Offers one pixel word, holding back first at the current gap rate, and
	// records what the converter owes for it once the word is taken.
	task automatic offer_pixel(input pix_t px, input bit typed, input hls_t want);
		@(negedge clk);
		while ($urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		hls_pending.push_back(typed ? want : hls_of(px));
	endtask

	// The receiver changes its ready only at the falling edge.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Result check and watchdog, both on the rising edge.
	always @(posedge clk) begin
		hls_t got;
		hls_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (hls_pending.size() == 0) begin
				$display("%0t: unexpected word %h", $time, got);
				errors++;
			end else begin
				want = hls_pending.pop_front();
				if (got.hue !== want.hue) begin
					$display("%0t: hue expected %0d actual %0d", $time, want.hue, got.hue);
					errors++;
				end
				if (got.lig !== want.lig) begin
					$display("%0t: lightness expected %0d actual %0d", $time,
						want.lig, got.lig);
					errors++;
				end
				if (got.sat !== want.sat) begin
					$display("%0t: saturation expected %0d actual %0d", $time,
						want.sat, got.sat);
					errors++;
				end
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no word accepted for %0d cycles", $time, idle_cycles);
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		hls_t want;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Directed rows with both sides flowing freely.
		foreach (dir_rows[i]) begin
			want = '{dir_rows[i].sat, dir_rows[i].lig, dir_rows[i].hue};
			offer_pixel('{dir_rows[i].blue, dir_rows[i].green, dir_rows[i].red},
				dir_rows[i].typed, want);
		end

		// Random pixels, one phase per pattern of sender gaps and receiver stalls.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 75; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 75; end
				default: begin gap_pct = 21; stall_pct = 21; end
			endcase
			repeat (RANDOM_PER_PHASE) offer_pixel(random_pixel(), 1'b0, '0);
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		// Drain; the watchdog bounds this wait if the pipeline hangs.
		while (hls_pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
